/* design/sfd_pkg.sv */
`timescale 1ns / 1ps
// sfd_pkg: widths, types, register codes and sample arithmetic helpers
// shared by every module of the stereo feedback delay; no dependencies
package sfd_pkg;

  localparam int STORE_DEPTH    = 131072;
  localparam int SAMPLE_BITS    = 24;
  localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
  localparam int FRAME_BITS     = 2 * SAMPLE_BITS;
  localparam int GAIN_BITS      = 16;
  localparam int FB_BITS        = 15;
  localparam int DELAY_BITS     = 17;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;
  localparam int FRAC_BITS      = 15;
  localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SCALE_BITS     = SAMPLE_BITS + 2;
  localparam int SUM_BITS       = SCALE_BITS + 1;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam logic [GAIN_BITS-1:0]  DRY_GAIN_RESET      = GAIN_BITS'(32768);
  localparam logic [GAIN_BITS-1:0]  WET_GAIN_RESET      = GAIN_BITS'(16384);
  localparam logic [FB_BITS-1:0]    FEEDBACK_GAIN_RESET = FB_BITS'(24576);
  localparam logic [DELAY_BITS-1:0] DELAY_RESET         = DELAY_BITS'(24000);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SCALE_BITS-1:0]  scaled_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [FRAME_BITS-1:0]         frame_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DRY_GAIN      = 2'd0,
    REG_WET_GAIN      = 2'd1,
    REG_FEEDBACK_GAIN = 2'd2,
    REG_DELAY_SAMPLES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] dry;
    logic [GAIN_BITS-1:0] wet;
    logic [FB_BITS-1:0]   feedback;
  } gains_t;

  // how the delayed sample is sourced in the read stage
  typedef struct packed {
    logic fwd_hit;
    logic rd_valid;
  } rd_ctrl_t;

  // q1.15 product back to sample scale, rounded toward zero
  function automatic scaled_t scale_q15(input prod_t p);
    prod_t biased;
    biased = p + (p[PROD_BITS-1] ? prod_t'((1 << FRAC_BITS) - 1) : prod_t'(0));
    return SCALE_BITS'(biased >>> FRAC_BITS);
  endfunction

  // clamp to the signed sample range
  function automatic sample_t sat_sample(input sum_t v);
    logic [SUM_BITS-SAMPLE_BITS:0] top;
    top = v[SUM_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

/* design/stereo_feedback_delay.sv */
`timescale 1ns / 1ps
// stereo_feedback_delay: top level of the stereo echo, position control,
// forwarding, interlock and configuration; uses sfd_pkg, sfd_store,
// sfd_chan and sfd_out_fifo
//
// usage
//   input channel: in_valid/in_ready carry one stereo frame (left_in,
//   right_in) per transfer; output channel: out_valid/out_ready carry the
//   mixed frame (left_out, right_out), one result per input frame, in order
//   configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data,
//   always ready; write it only while no frame is in flight
//   path: an accepted frame passes the read and mix stages into the result queue
//   throughput: one frame per cycle while in_ready holds; with a delay of
//   one frame (modulo the store depth) each frame waits for the previous
//   frame's feedback value, a stall that comes from the read-multiply-write
//   loop through the store's single write port
//   reset: gains and delay return to their defaults and the write position to
//   zero; there is no clearing pass, entries not yet written since reset read
//   as zero by tracking how far the write position has got
//   receiver stall: results collect in a four-entry queue; in_ready drops
//   once the queue plus the frames still in the pipeline would fill it
module stereo_feedback_delay (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sfd_pkg::sample_t                    left_in,
  input  sfd_pkg::sample_t                    right_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sfd_pkg::sample_t                    left_out,
  output sfd_pkg::sample_t                    right_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import sfd_pkg::*;

  // configuration registers
  gains_t                gains;
  logic [DELAY_BITS-1:0] delay_samples;

  // write position and fill tracking
  addr_t wr_pos;
  logic  filled;

  // request stage
  addr_t rd_addr;
  logic  rd_valid0;
  logic  hazard;
  logic  in_xfer;
  logic [FIFO_CNT_BITS:0] occupancy;

  // read stage
  logic     s1_valid;
  addr_t    s1_wr;
  addr_t    s1_rd;
  logic     s1_rdv;
  sample_t  s1_left;
  sample_t  s1_right;
  rd_ctrl_t s1_ctrl;

  // mix stage
  logic  s2_valid;
  addr_t s2_wr;

  // last write, for forwarding past the store's read-before-write
  logic   wb_valid;
  addr_t  wb_addr;
  frame_t wb_data;

  frame_t  mem_frame;
  sample_t left_mix;
  sample_t right_mix;
  sample_t left_store;
  sample_t right_store;
  frame_t  out_frame;
  logic [FIFO_CNT_BITS-1:0] fifo_count;

  // configuration writes, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.dry      <= DRY_GAIN_RESET;
      gains.wet      <= WET_GAIN_RESET;
      gains.feedback <= FEEDBACK_GAIN_RESET;
      delay_samples  <= DELAY_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DRY_GAIN:      gains.dry      <= cfg_data[GAIN_BITS-1:0];
        REG_WET_GAIN:      gains.wet      <= cfg_data[GAIN_BITS-1:0];
        REG_FEEDBACK_GAIN: gains.feedback <= cfg_data[FB_BITS-1:0];
        REG_DELAY_SAMPLES: delay_samples  <= cfg_data[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read position wraps with the power-of-two store depth
  assign rd_addr   = wr_pos - ADDR_BITS'(delay_samples);
  assign rd_valid0 = filled || (rd_addr < wr_pos);

  // the frame in the read stage has not produced its store value yet
  assign hazard    = s1_valid && (rd_addr == s1_wr);
  assign occupancy = (FIFO_CNT_BITS+1)'(fifo_count)
                   + (FIFO_CNT_BITS+1)'(s1_valid)
                   + (FIFO_CNT_BITS+1)'(s2_valid);
  assign in_ready  = !hazard && (occupancy < (FIFO_CNT_BITS+1)'(FIFO_DEPTH));
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos   <= '0;
      filled   <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer;
      s2_valid <= s1_valid;
      if (in_xfer) begin
        wr_pos <= wr_pos + 1'b1;
        if (wr_pos == addr_t'(STORE_DEPTH - 1)) begin
          filled <= 1'b1;
        end
      end
      if (s2_valid) begin
        wb_valid <= 1'b1;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_wr    <= wr_pos;
      s1_rd    <= rd_addr;
      s1_rdv   <= rd_valid0;
      s1_left  <= left_in;
      s1_right <= right_in;
    end
    s2_wr <= s1_wr;
    if (s2_valid) begin
      wb_addr <= s2_wr;
      wb_data <= {left_store, right_store};
    end
  end

  assign s1_ctrl.fwd_hit  = wb_valid && (s1_rd == wb_addr);
  assign s1_ctrl.rd_valid = s1_rdv;

  sfd_store u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (mem_frame),
    .wr_en   (s2_valid),
    .wr_addr (s2_wr),
    .wr_data ({left_store, right_store})
  );

  sfd_chan u_chan_left (
    .clk          (clk),
    .gains        (gains),
    .ctrl         (s1_ctrl),
    .in_sample    (s1_left),
    .mem_sample   (mem_frame[FRAME_BITS-1:SAMPLE_BITS]),
    .fwd_sample   (wb_data[FRAME_BITS-1:SAMPLE_BITS]),
    .mix_sample   (left_mix),
    .store_sample (left_store)
  );

  sfd_chan u_chan_right (
    .clk          (clk),
    .gains        (gains),
    .ctrl         (s1_ctrl),
    .in_sample    (s1_right),
    .mem_sample   (mem_frame[SAMPLE_BITS-1:0]),
    .fwd_sample   (wb_data[SAMPLE_BITS-1:0]),
    .mix_sample   (right_mix),
    .store_sample (right_store)
  );

  sfd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data ({left_mix, right_mix}),
    .pop       (out_ready),
    .out_valid (out_valid),
    .out_data  (out_frame),
    .count     (fifo_count)
  );

  assign left_out  = out_frame[FRAME_BITS-1:SAMPLE_BITS];
  assign right_out = out_frame[SAMPLE_BITS-1:0];

`ifndef ASSERT_OFF
  // a frame is never taken while its delayed sample is still being computed
  a_no_hazard_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !(s1_valid && (rd_addr == s1_wr)))
    else $error("frame accepted across the feedback interlock");

  // the credit check keeps the result queue from overflowing
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (FIFO_CNT_BITS+1)'(FIFO_DEPTH))
    else $error("result queue over-committed");

  // one store entry per accepted frame
  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> wr_pos == addr_t'($past(wr_pos) + 1'b1))
    else $error("write position did not advance");

  // once the store has wrapped every entry holds written data
  a_filled_sticky: assert property (@(posedge clk) disable iff (rst)
    filled |=> filled)
    else $error("fill flag dropped");

  a_s2_follows_s1: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid))
    else $error("mix stage valid without a read stage frame");
`endif

endmodule

/* design/sfd_store.sv */
`timescale 1ns / 1ps
// sfd_store: circular frame store, one write port and one registered read port
// depends on sfd_pkg
module sfd_store (
  input  logic           clk,
  input  sfd_pkg::addr_t rd_addr,
  output sfd_pkg::frame_t rd_data,
  input  logic           wr_en,
  input  sfd_pkg::addr_t wr_addr,
  input  sfd_pkg::frame_t wr_data
);
  import sfd_pkg::*;

  frame_t mem [STORE_DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/sfd_chan.sv */
`timescale 1ns / 1ps
// sfd_chan: one channel of the echo datapath, delayed-sample select,
// gain products and mix/feedback sums; depends on sfd_pkg
module sfd_chan (
  input  logic              clk,
  input  sfd_pkg::gains_t   gains,
  input  sfd_pkg::rd_ctrl_t ctrl,
  input  sfd_pkg::sample_t  in_sample,
  input  sfd_pkg::sample_t  mem_sample,
  input  sfd_pkg::sample_t  fwd_sample,
  output sfd_pkg::sample_t  mix_sample,
  output sfd_pkg::sample_t  store_sample
);
  import sfd_pkg::*;

  sample_t delayed;
  prod_t   dry_prod;
  prod_t   wet_prod;
  prod_t   fb_prod;
  sample_t in_s2;
  sum_t    mix_sum;
  sum_t    store_sum;

  // delayed sample: the forwarded last write, else the store; never-written entries read as zero
  always_comb begin
    if (ctrl.fwd_hit) begin
      delayed = fwd_sample;
    end else if (ctrl.rd_valid) begin
      delayed = mem_sample;
    end else begin
      delayed = '0;
    end
  end

  always_ff @(posedge clk) begin
    dry_prod <= $signed({1'b0, gains.dry}) * in_sample;
    wet_prod <= $signed({1'b0, gains.wet}) * delayed;
    fb_prod  <= $signed({2'b00, gains.feedback}) * delayed;
    in_s2    <= in_sample;
  end

  always_comb begin
    mix_sum   = SUM_BITS'(scale_q15(dry_prod)) + SUM_BITS'(scale_q15(wet_prod));
    store_sum = SUM_BITS'(in_s2) + SUM_BITS'(scale_q15(fb_prod));
  end

  assign mix_sample   = sat_sample(mix_sum);
  assign store_sample = sat_sample(store_sum);

endmodule

/* design/sfd_out_fifo.sv */
`timescale 1ns / 1ps
// sfd_out_fifo: small result queue between the datapath and the output port
// depends on sfd_pkg
module sfd_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  sfd_pkg::frame_t                   push_data,
  input  logic                              pop,
  output logic                              out_valid,
  output sfd_pkg::frame_t                   out_data,
  output logic [sfd_pkg::FIFO_CNT_BITS-1:0] count
);
  import sfd_pkg::*;

  frame_t                   entries [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] head;
  logic [FIFO_PTR_BITS-1:0] tail;
  logic                     do_pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[head];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (do_pop) begin
        head <= head + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
